/* src/pointer_packet_tracker_top_macros.svh */
// assertion macros for the pointer packet tracker
// included by the rtl files that carry concurrent checks; no other dependencies
`ifndef POINTER_PACKET_TRACKER_TOP_MACROS_SVH
`define POINTER_PACKET_TRACKER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define PPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// next-cycle implication, disabled during reset
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PPT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/ppt_pkg.sv */
// shared types and constants for the pointer packet tracker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ppt_pkg;

  // position of the next byte inside a 3-byte packet
  typedef enum logic [1:0] {
    POS_FLAG = 2'd0,
    POS_X    = 2'd1,
    POS_Y    = 2'd2
  } byte_pos_t;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ENABLE = 2'd2;

  // flag byte bit positions
  localparam int BIT_LEFT   = 0;
  localparam int BIT_RIGHT  = 1;
  localparam int BIT_MIDDLE = 2;
  localparam int BIT_SYNC   = 3;
  localparam int BIT_XSIGN  = 4;
  localparam int BIT_YSIGN  = 5;
  localparam int BIT_XOVF   = 6;
  localparam int BIT_YOVF   = 7;

  // reset values of the configuration registers
  localparam logic [12:0] WIDTH_RST  = 13'd1024;
  localparam logic [12:0] HEIGHT_RST = 13'd768;

endpackage : ppt_pkg
`default_nettype wire

/* src/pointer_packet_tracker_top.sv */
// pointer packet tracker top level: byte framing, cursor tracking, output skid
// depends on ppt_pkg and pointer_packet_tracker_top_macros.svh
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   in_*  : one device byte per beat, in_tdata = data_byte, in_tuser = batch_start
//           (batch_start clears the click flag before the byte is handled)
//   out_* : one result beat for every third decoded byte (end of a packet)
//   cfg_* : register writes, index 0 width, 1 height, 2 enable; always ready
// A packet's third byte is decoded in the cycle it is accepted and its result
// is registered into the output register, or into the skid register while the
// output is held. Bytes are taken one per cycle while in_tready is high; the
// single add-and-clamp path lies ahead of the result register. A first byte
// lacking the sync bit is dropped; all bytes are dropped while enable is 0.
// Reset (synchronous, rst_n low) empties the output, returns the framer to the
// first byte, centers the cursor, releases the buttons and loads the default
// 1024 x 768 screen with the block enabled.
// When the receiver stalls, one more result is held in a skid register; bytes
// keep being accepted until that skid register fills, then in_tready drops.
module pointer_packet_tracker_top #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]            in_tuser,   // [0] batch_start
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // cursor_x, cursor_y (COORD_BITS each), delta_x (9), delta_y (10), left_down,
  // right_down, middle_down, clicked, moved, changed, then zero fill
  output logic [((2*COORD_BITS+25+7)/8)*8-1:0] out_tdata,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [12:0]           cfg_data
);

`include "pointer_packet_tracker_top_macros.svh"

  localparam int CB    = COORD_BITS;
  localparam int RAWW  = 2*CB + 25;
  localparam int OW    = ((RAWW + 7) / 8) * 8;
  localparam int PADW  = OW - RAWW;
  localparam logic [16:0]   COORD_MAX17 = 17'((1 << CB) - 1);
  localparam logic [CB-1:0] POS_X_RST   = CB'(511);
  localparam logic [CB-1:0] POS_Y_RST   = CB'(383);

  // highest cursor coordinate for a screen size, saturated to the coordinate range
  function automatic logic [CB-1:0] limit_of(input logic [12:0] size);
    logic [12:0] m;
    logic [16:0] m17;
    m   = (size == 13'd0) ? 13'd0 : size - 13'd1;
    m17 = {4'b0000, m};
    if (m17 > COORD_MAX17) begin
      limit_of = COORD_MAX17[CB-1:0];
    end else begin
      limit_of = m17[CB-1:0];
    end
  endfunction

  // configuration registers, limits kept precomputed
  logic [CB-1:0] lim_x_r, lim_y_r;
  logic          enable_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_x_r  <= limit_of(ppt_pkg::WIDTH_RST);
      lim_y_r  <= limit_of(ppt_pkg::HEIGHT_RST);
      enable_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppt_pkg::CFG_WIDTH:  lim_x_r  <= limit_of(cfg_data);
        ppt_pkg::CFG_HEIGHT: lim_y_r  <= limit_of(cfg_data);
        ppt_pkg::CFG_ENABLE: enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // tracker state
  ppt_pkg::byte_pos_t pos_r, pos_nxt;
  logic [7:0]    flag_r, flag_nxt;
  logic [7:0]    xbyte_r, xbyte_nxt;
  logic [CB-1:0] px_r, px_nxt;
  logic [CB-1:0] py_r, py_nxt;
  logic [2:0]    btn_r, btn_nxt;
  logic          click_r, click_nxt;

  logic          skid_valid_r;
  logic          out_valid_r;
  logic [OW-1:0] out_data_r, skid_data_r;

  logic          in_fire;
  logic          produce;
  logic [OW-1:0] res;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  // packet arithmetic from the stored bytes and the current third byte
  logic          ovf;
  logic [8:0]    dx, ry;
  logic [9:0]    dy;
  logic [CB+1:0] sum_x, sum_y;
  logic [CB-1:0] clamp_x, clamp_y;

  assign ovf   = flag_r[ppt_pkg::BIT_XOVF] || flag_r[ppt_pkg::BIT_YOVF];
  assign dx    = {flag_r[ppt_pkg::BIT_XSIGN], xbyte_r};
  assign ry    = {flag_r[ppt_pkg::BIT_YSIGN], in_tdata};
  assign dy    = 10'd0 - {ry[8], ry};
  assign sum_x = {2'b00, px_r} + {{(CB-7){dx[8]}}, dx};
  assign sum_y = {2'b00, py_r} + {{(CB-8){dy[9]}}, dy};

  // clamp to zero and to the screen limit
  always_comb begin
    if (sum_x[CB+1]) begin
      clamp_x = '0;
    end else if (sum_x[CB:0] > {1'b0, lim_x_r}) begin
      clamp_x = lim_x_r;
    end else begin
      clamp_x = sum_x[CB-1:0];
    end
    if (sum_y[CB+1]) begin
      clamp_y = '0;
    end else if (sum_y[CB:0] > {1'b0, lim_y_r}) begin
      clamp_y = lim_y_r;
    end else begin
      clamp_y = sum_y[CB-1:0];
    end
  end

  // framer next state and result assembly
  logic       moved, changed, click_base;
  logic [8:0] res_dx;
  logic [9:0] res_dy;

  always_comb begin
    pos_nxt    = pos_r;
    flag_nxt   = flag_r;
    xbyte_nxt  = xbyte_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    btn_nxt    = btn_r;
    produce    = 1'b0;
    moved      = 1'b0;
    changed    = 1'b0;
    res_dx     = '0;
    res_dy     = '0;
    click_base = (in_fire && in_tuser[0]) ? 1'b0 : click_r;
    click_nxt  = click_base;
    if (in_fire && enable_r) begin
      unique case (pos_r)
        ppt_pkg::POS_FLAG: begin
          if (in_tdata[ppt_pkg::BIT_SYNC]) begin
            flag_nxt = in_tdata;
            pos_nxt  = ppt_pkg::POS_X;
          end
        end
        ppt_pkg::POS_X: begin
          xbyte_nxt = in_tdata;
          pos_nxt   = ppt_pkg::POS_Y;
        end
        ppt_pkg::POS_Y: begin
          pos_nxt = ppt_pkg::POS_FLAG;
          produce = 1'b1;
          if (!ovf) begin
            px_nxt    = clamp_x;
            py_nxt    = clamp_y;
            btn_nxt   = flag_r[2:0];
            res_dx    = dx;
            res_dy    = dy;
            if (flag_r[ppt_pkg::BIT_LEFT] && !btn_r[0]) begin
              click_nxt = 1'b1;
            end
            moved   = (dx != 9'd0) || (ry != 9'd0);
            changed = moved || click_nxt || (flag_r[2:0] != btn_r);
          end
        end
        default: pos_nxt = ppt_pkg::POS_FLAG;
      endcase
    end
    res = {{PADW{1'b0}}, changed, moved, click_nxt,
           btn_nxt[ppt_pkg::BIT_MIDDLE], btn_nxt[ppt_pkg::BIT_RIGHT],
           btn_nxt[ppt_pkg::BIT_LEFT], res_dy, res_dx, py_nxt, px_nxt};
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= ppt_pkg::POS_FLAG;
      px_r    <= POS_X_RST;
      py_r    <= POS_Y_RST;
      btn_r   <= 3'b000;
      click_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      btn_r   <= btn_nxt;
      click_r <= click_nxt;
    end
  end

  // stored packet bytes, payload only
  always_ff @(posedge clk) begin
    flag_r  <= flag_nxt;
    xbyte_r <= xbyte_nxt;
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && out_tready) begin
      if (skid_valid_r) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else if (produce) begin
        out_data_r <= res;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (produce) begin
      if (!out_valid_r) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `PPT_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `PPT_ASSERT_NEXT(a_result_lands, clk, rst_n, produce, out_valid_r)
  `PPT_ASSERT_IMPL(a_moved_changed, clk, rst_n, out_valid_r && out_data_r[2*CB+23],
                   out_data_r[2*CB+24])
  `PPT_ASSERT_IMPL(a_still_zero_delta, clk, rst_n, out_valid_r && !out_data_r[2*CB+23],
                   out_data_r[2*CB+18:2*CB] == 19'd0)

endmodule : pointer_packet_tracker_top
`default_nettype wire
